// ===== design/sts_pkg.sv =====
// ----------------------------------------------------------------------------
// sts_pkg
// Types, constants and the control store of the spiral tile order generator.
// ----------------------------------------------------------------------------
package sts_pkg;

  // field and datapath widths
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;
  localparam int DIM_W      = 14;
  localparam int TILE_W     = 9;
  localparam int POS_W      = 16;
  localparam int ID_W       = 26;
  localparam int ORG_W      = 13;
  localparam int PROD_W     = DIM_W + TILE_W;
  localparam int DIVIDEND_W = 15;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);
  localparam int PC_W       = 4;

  // register indexes
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_IMAGE_WIDTH  = 2'd0;
  localparam cfg_idx_t CFG_IMAGE_HEIGHT = 2'd1;
  localparam cfg_idx_t CFG_TILE_EDGE    = 2'd2;

  // register values after reset
  localparam int IMAGE_WIDTH_RESET  = 1920;
  localparam int IMAGE_HEIGHT_RESET = 1080;
  localparam int TILE_EDGE_RESET    = 64;

  // datapath operations driven by the control word
  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_DIV_LOAD_W,
    OP_STORE_COLS,
    OP_DIV_LOAD_H,
    OP_START_WALK,
    OP_MUL,
    OP_EMIT_TILE,
    OP_ADVANCE,
    OP_EMIT_DONE
  } op_t;

  // jump conditions
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_REQ,
    C_NO_RESTART,
    C_DIV_BUSY,
    C_FINISHED,
    C_OUTSIDE,
    C_OUT_FULL
  } cond_t;

  typedef logic [PC_W-1:0] pc_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } uword_t;

  // status flags seen by the sequencer
  typedef struct packed {
    logic no_req;
    logic restart;
    logic div_busy;
    logic finished;
    logic outside;
    logic out_full;
  } stat_t;

  // program steps
  localparam pc_t PC_WAIT        = 4'd0;
  localparam pc_t PC_CHK_RESTART = 4'd1;
  localparam pc_t PC_DIV_W       = 4'd2;
  localparam pc_t PC_DIV_W_RUN   = 4'd3;
  localparam pc_t PC_STORE_COLS  = 4'd4;
  localparam pc_t PC_DIV_H       = 4'd5;
  localparam pc_t PC_DIV_H_RUN   = 4'd6;
  localparam pc_t PC_START       = 4'd7;
  localparam pc_t PC_CHK_DONE    = 4'd8;
  localparam pc_t PC_CHK_INSIDE  = 4'd9;
  localparam pc_t PC_MUL         = 4'd10;
  localparam pc_t PC_WAIT_TILE   = 4'd11;
  localparam pc_t PC_EMIT_TILE   = 4'd12;
  localparam pc_t PC_SKIP        = 4'd13;
  localparam pc_t PC_WAIT_DONE   = 4'd14;
  localparam pc_t PC_EMIT_DONE   = 4'd15;

  // control store: jump to target when the condition holds, else fall through
  function automatic uword_t ucode_rom(pc_t pc);
    uword_t w;
    case (pc)
      PC_WAIT:        w = '{OP_ACCEPT,     C_NO_REQ,     PC_WAIT};
      PC_CHK_RESTART: w = '{OP_NOP,        C_NO_RESTART, PC_CHK_DONE};
      PC_DIV_W:       w = '{OP_DIV_LOAD_W, C_NEVER,      PC_WAIT};
      PC_DIV_W_RUN:   w = '{OP_NOP,        C_DIV_BUSY,   PC_DIV_W_RUN};
      PC_STORE_COLS:  w = '{OP_STORE_COLS, C_NEVER,      PC_WAIT};
      PC_DIV_H:       w = '{OP_DIV_LOAD_H, C_NEVER,      PC_WAIT};
      PC_DIV_H_RUN:   w = '{OP_NOP,        C_DIV_BUSY,   PC_DIV_H_RUN};
      PC_START:       w = '{OP_START_WALK, C_NEVER,      PC_WAIT};
      PC_CHK_DONE:    w = '{OP_NOP,        C_FINISHED,   PC_WAIT_DONE};
      PC_CHK_INSIDE:  w = '{OP_NOP,        C_OUTSIDE,    PC_SKIP};
      PC_MUL:         w = '{OP_MUL,        C_NEVER,      PC_WAIT};
      PC_WAIT_TILE:   w = '{OP_NOP,        C_OUT_FULL,   PC_WAIT_TILE};
      PC_EMIT_TILE:   w = '{OP_EMIT_TILE,  C_ALWAYS,     PC_WAIT};
      PC_SKIP:        w = '{OP_ADVANCE,    C_ALWAYS,     PC_CHK_DONE};
      PC_WAIT_DONE:   w = '{OP_NOP,        C_OUT_FULL,   PC_WAIT_DONE};
      PC_EMIT_DONE:   w = '{OP_EMIT_DONE,  C_ALWAYS,     PC_WAIT};
      default:        w = '{OP_NOP,        C_ALWAYS,     PC_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ===== design/sts_in_if.sv =====
// ----------------------------------------------------------------------------
// sts_in_if
// Request channel: valid/ready handshake carrying the restart flag.
// ----------------------------------------------------------------------------
interface sts_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

// ===== design/sts_out_if.sv =====
// ----------------------------------------------------------------------------
// sts_out_if
// Result channel: valid/ready handshake carrying one tile descriptor.
// ----------------------------------------------------------------------------
interface sts_out_if
  import sts_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [ID_W-1:0]   tile_id;
  logic [ORG_W-1:0]  origin_x;
  logic [ORG_W-1:0]  origin_y;
  logic [TILE_W-1:0] size_x;
  logic [TILE_W-1:0] size_y;
  logic              done_res;

  modport source (output valid, output tile_id, output origin_x, output origin_y,
                  output size_x, output size_y, output done_res, input ready);
  modport sink   (input valid, input tile_id, input origin_x, input origin_y,
                  input size_x, input size_y, input done_res, output ready);
endinterface

// ===== design/sts_cfg_if.sv =====
// ----------------------------------------------------------------------------
// sts_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface sts_cfg_if
  import sts_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/spiral_tile_order_generator.sv =====
// ----------------------------------------------------------------------------
// spiral_tile_order_generator
// Hands out image tiles in a centre-out spiral, one tile per request.
// Per request: the end of the walk is checked, off-image positions are stepped
// over, the origin is multiplied out and the tile emitted, or a done result.
// A restart first runs two 15-bit divisions in a bit-per-cycle divider.
// A new request is taken only in the wait step, after the last result is issued.
// Reset: synchronous, active low; registers and a 30 by 17 grid at defaults.
// ----------------------------------------------------------------------------
module spiral_tile_order_generator
  import sts_pkg::*;
#(
  parameter int MAX_IMAGE_EDGE = 8192,
  parameter int MAX_TILE_EDGE  = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  sts_in_if.sink      in_ch,
  sts_out_if.source   out_ch,
  sts_cfg_if.sink     cfg_ch
);

  // grid of the reset register values after clamping
  localparam int RST_W    = (IMAGE_WIDTH_RESET > MAX_IMAGE_EDGE) ?
                            MAX_IMAGE_EDGE : IMAGE_WIDTH_RESET;
  localparam int RST_H    = (IMAGE_HEIGHT_RESET > MAX_IMAGE_EDGE) ?
                            MAX_IMAGE_EDGE : IMAGE_HEIGHT_RESET;
  localparam int RST_T    = (TILE_EDGE_RESET > MAX_TILE_EDGE) ?
                            MAX_TILE_EDGE : TILE_EDGE_RESET;
  localparam int RST_COLS = (RST_W + RST_T - 1) / RST_T;
  localparam int RST_ROWS = (RST_H + RST_T - 1) / RST_T;

  logic [DIM_W-1:0]  width_r, width_nxt;
  logic [DIM_W-1:0]  height_r, height_nxt;
  logic [TILE_W-1:0] tile_r, tile_nxt;
  logic [DIM_W-1:0]  eff_w, eff_h;
  logic [TILE_W-1:0] eff_t;
  logic              in_accept;
  op_t               op;
  stat_t             stat;

  // configuration writes
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    tile_nxt   = tile_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_IMAGE_WIDTH:  width_nxt  = cfg_ch.data;
        CFG_IMAGE_HEIGHT: height_nxt = cfg_ch.data;
        CFG_TILE_EDGE:    tile_nxt   = cfg_ch.data[TILE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(IMAGE_WIDTH_RESET);
      height_r <= DIM_W'(IMAGE_HEIGHT_RESET);
      tile_r   <= TILE_W'(TILE_EDGE_RESET);
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      tile_r   <= tile_nxt;
    end
  end

  // clamp the registers to their working ranges
  always_comb begin
    if (width_r == '0) begin
      eff_w = DIM_W'(1);
    end else if (width_r > MAX_IMAGE_EDGE) begin
      eff_w = DIM_W'(MAX_IMAGE_EDGE);
    end else begin
      eff_w = width_r;
    end
    if (height_r == '0) begin
      eff_h = DIM_W'(1);
    end else if (height_r > MAX_IMAGE_EDGE) begin
      eff_h = DIM_W'(MAX_IMAGE_EDGE);
    end else begin
      eff_h = height_r;
    end
    if (tile_r == '0) begin
      eff_t = TILE_W'(1);
    end else if (tile_r > MAX_TILE_EDGE) begin
      eff_t = TILE_W'(MAX_TILE_EDGE);
    end else begin
      eff_t = tile_r;
    end
  end

  // take a request only in the wait step
  assign in_ch.ready = (op == OP_ACCEPT);
  assign in_accept   = in_ch.valid && in_ch.ready;

  sts_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .op    (op)
  );

  sts_datapath #(
    .RST_COLS (RST_COLS),
    .RST_ROWS (RST_ROWS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .op           (op),
    .in_accept    (in_accept),
    .in_restart   (in_ch.restart),
    .eff_w        (eff_w),
    .eff_h        (eff_h),
    .eff_t        (eff_t),
    .out_ready    (out_ch.ready),
    .stat         (stat),
    .out_valid    (out_ch.valid),
    .out_tile_id  (out_ch.tile_id),
    .out_origin_x (out_ch.origin_x),
    .out_origin_y (out_ch.origin_y),
    .out_size_x   (out_ch.size_x),
    .out_size_y   (out_ch.size_y),
    .out_done_res (out_ch.done_res)
  );

  // a done result carries no tile
  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.done_res |->
      (out_ch.tile_id == '0) && (out_ch.origin_x == '0) && (out_ch.origin_y == '0)
      && (out_ch.size_x == '0) && (out_ch.size_y == '0))
    else $error("done result with non-zero tile fields");

  // never overwrite a result still waiting
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_EMIT_TILE) || (op == OP_EMIT_DONE) |-> !out_ch.valid)
    else $error("result register overwritten");

  // one request at a time
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("request accepted while one is in progress");

endmodule

// ===== design/sts_divider.sv =====
// ----------------------------------------------------------------------------
// sts_divider
// Restoring divider, one quotient bit per cycle, for the tile grid size.
// ----------------------------------------------------------------------------
module sts_divider
  import sts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [TILE_W-1:0]     divisor,
  output logic                  busy,
  output logic [DIM_W-1:0]      quotient
);

  logic                  busy_r, busy_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [TILE_W-1:0]     rem_r, rem_nxt;
  logic [TILE_W-1:0]     div_r, div_nxt;
  logic [TILE_W:0]       rem_sh;
  logic                  ge;

  // trial subtraction of the shifted remainder
  assign rem_sh = {rem_r, quo_r[DIVIDEND_W-1]};
  assign ge     = rem_sh >= {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIVIDEND_W - 1);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DIVIDEND_W-2:0], ge};
      rem_nxt = ge ? TILE_W'(rem_sh - {1'b0, div_r}) : rem_sh[TILE_W-1:0];
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // operand registers carry no reset
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r[DIM_W-1:0];

endmodule

// ===== design/sts_datapath.sv =====
// ----------------------------------------------------------------------------
// sts_datapath
// Spiral walk state, grid size, origin multiplier and result register.
// ----------------------------------------------------------------------------
module sts_datapath
  import sts_pkg::*;
#(
  parameter int RST_COLS = 30,
  parameter int RST_ROWS = 17
) (
  input  logic              clk,
  input  logic              rst_n,
  input  op_t               op,
  input  logic              in_accept,
  input  logic              in_restart,
  input  logic [DIM_W-1:0]  eff_w,
  input  logic [DIM_W-1:0]  eff_h,
  input  logic [TILE_W-1:0] eff_t,
  input  logic              out_ready,
  output stat_t             stat,
  output logic              out_valid,
  output logic [ID_W-1:0]   out_tile_id,
  output logic [ORG_W-1:0]  out_origin_x,
  output logic [ORG_W-1:0]  out_origin_y,
  output logic [TILE_W-1:0] out_size_x,
  output logic [TILE_W-1:0] out_size_y,
  output logic              out_done_res
);

  logic                    restart_r, restart_nxt;
  logic [DIM_W-1:0]        cols_r, cols_nxt;
  logic [DIM_W-1:0]        rows_r, rows_nxt;
  logic signed [POS_W-1:0] walk_x_r, walk_x_nxt;
  logic signed [POS_W-1:0] walk_y_r, walk_y_nxt;
  logic [1:0]              heading_r, heading_nxt;
  logic [DIM_W-1:0]        steps_r, steps_nxt;
  logic [DIM_W-1:0]        leg_r, leg_nxt;
  logic [ID_W-1:0]         id_r, id_nxt;
  logic                    fin_r, fin_nxt;
  logic [PROD_W-1:0]       ox_r, ox_nxt;
  logic [PROD_W-1:0]       oy_r, oy_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]         tile_id_r, tile_id_nxt;
  logic [ORG_W-1:0]        org_x_r, org_x_nxt;
  logic [ORG_W-1:0]        org_y_r, org_y_nxt;
  logic [TILE_W-1:0]       size_x_r, size_x_nxt;
  logic [TILE_W-1:0]       size_y_r, size_y_nxt;
  logic                    done_r, done_nxt;

  logic                    div_start;
  logic                    div_busy;
  logic [DIM_W-1:0]        div_quot;
  logic [DIVIDEND_W-1:0]   div_dividend;

  logic signed [POS_W-1:0] cols_s, rows_s;
  logic                    cur_inside;
  logic                    turn;
  logic [1:0]              hd_a;
  logic [DIM_W-1:0]        steps_a, leg_a;
  logic signed [POS_W-1:0] x_a, y_a;
  logic                    fin_a;

  // size of a tile, clipped at the image edge
  function automatic logic [TILE_W-1:0] clip_size(logic [TILE_W-1:0] t,
                                                   logic [DIM_W-1:0]  edge_px,
                                                   logic [PROD_W-1:0] origin);
    logic [PROD_W-1:0] room;
    room = {{(PROD_W-DIM_W){1'b0}}, edge_px} - origin;
    if (origin >= {{(PROD_W-DIM_W){1'b0}}, edge_px}) begin
      return '0;
    end else if ({{(PROD_W-TILE_W){1'b0}}, t} < room) begin
      return t;
    end else begin
      return room[TILE_W-1:0];
    end
  endfunction

  // grid size: ceil(edge / tile)
  assign div_start    = (op == OP_DIV_LOAD_W) || (op == OP_DIV_LOAD_H);
  assign div_dividend = {1'b0, (op == OP_DIV_LOAD_H) ? eff_h : eff_w}
                      + {{(DIVIDEND_W-TILE_W){1'b0}}, eff_t} - 1'b1;

  sts_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (eff_t),
    .busy     (div_busy),
    .quotient (div_quot)
  );

  // current position inside the grid
  assign cols_s     = $signed({{(POS_W-DIM_W){1'b0}}, cols_r});
  assign rows_s     = $signed({{(POS_W-DIM_W){1'b0}}, rows_r});
  assign cur_inside = (walk_x_r >= 0) && (walk_x_r < cols_s)
                   && (walk_y_r >= 0) && (walk_y_r < rows_s);

  // one spiral step: turn at the end of a leg, lengthen the leg on even headings
  always_comb begin
    turn    = steps_r >= leg_r;
    hd_a    = turn ? heading_r + 2'd1 : heading_r;
    steps_a = (turn ? '0 : steps_r) + 1'b1;
    leg_a   = leg_r + {{(DIM_W-1){1'b0}}, turn & ~hd_a[0]};
    x_a     = walk_x_r;
    y_a     = walk_y_r;
    case (hd_a)
      2'd0:    y_a = walk_y_r - 2'sd1;
      2'd1:    x_a = walk_x_r - 2'sd1;
      2'd2:    y_a = walk_y_r + 2'sd1;
      default: x_a = walk_x_r + 2'sd1;
    endcase
    fin_a = !((x_a >= 0) && (x_a < cols_s)) && !((y_a >= 0) && (y_a < rows_s));
  end

  always_comb begin
    restart_nxt   = restart_r;
    cols_nxt      = cols_r;
    rows_nxt      = rows_r;
    walk_x_nxt    = walk_x_r;
    walk_y_nxt    = walk_y_r;
    heading_nxt   = heading_r;
    steps_nxt     = steps_r;
    leg_nxt       = leg_r;
    id_nxt        = id_r;
    fin_nxt       = fin_r;
    ox_nxt        = ox_r;
    oy_nxt        = oy_r;
    tile_id_nxt   = tile_id_r;
    org_x_nxt     = org_x_r;
    org_y_nxt     = org_y_r;
    size_x_nxt    = size_x_r;
    size_y_nxt    = size_y_r;
    done_nxt      = done_r;
    // drop the result once taken
    out_valid_nxt = out_valid_r && !out_ready;

    if (in_accept) begin
      restart_nxt = in_restart;
    end

    case (op)
      OP_STORE_COLS: begin
        cols_nxt = div_quot;
      end
      OP_START_WALK: begin
        rows_nxt    = div_quot;
        walk_x_nxt  = $signed({{(POS_W-DIM_W+1){1'b0}}, cols_r[DIM_W-1:1]});
        walk_y_nxt  = $signed({{(POS_W-DIM_W+1){1'b0}}, div_quot[DIM_W-1:1]});
        heading_nxt = 2'd0;
        steps_nxt   = '0;
        leg_nxt     = DIM_W'(1);
        id_nxt      = '0;
        fin_nxt     = 1'b0;
      end
      OP_MUL: begin
        ox_nxt = PROD_W'(walk_x_r[DIM_W-1:0]) * PROD_W'(eff_t);
        oy_nxt = PROD_W'(walk_y_r[DIM_W-1:0]) * PROD_W'(eff_t);
      end
      OP_EMIT_TILE: begin
        out_valid_nxt = 1'b1;
        tile_id_nxt   = id_r;
        org_x_nxt     = ox_r[ORG_W-1:0];
        org_y_nxt     = oy_r[ORG_W-1:0];
        size_x_nxt    = clip_size(eff_t, eff_w, ox_r);
        size_y_nxt    = clip_size(eff_t, eff_h, oy_r);
        done_nxt      = 1'b0;
        id_nxt        = id_r + 1'b1;
        walk_x_nxt    = x_a;
        walk_y_nxt    = y_a;
        heading_nxt   = hd_a;
        steps_nxt     = steps_a;
        leg_nxt       = leg_a;
        fin_nxt       = fin_r | fin_a;
      end
      OP_ADVANCE: begin
        walk_x_nxt  = x_a;
        walk_y_nxt  = y_a;
        heading_nxt = hd_a;
        steps_nxt   = steps_a;
        leg_nxt     = leg_a;
        fin_nxt     = fin_r | fin_a;
      end
      OP_EMIT_DONE: begin
        out_valid_nxt = 1'b1;
        tile_id_nxt   = '0;
        org_x_nxt     = '0;
        org_y_nxt     = '0;
        size_x_nxt    = '0;
        size_y_nxt    = '0;
        done_nxt      = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // walk state and control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      restart_r   <= 1'b0;
      cols_r      <= DIM_W'(RST_COLS);
      rows_r      <= DIM_W'(RST_ROWS);
      walk_x_r    <= POS_W'(RST_COLS / 2);
      walk_y_r    <= POS_W'(RST_ROWS / 2);
      heading_r   <= 2'd0;
      steps_r     <= '0;
      leg_r       <= DIM_W'(1);
      id_r        <= '0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      restart_r   <= restart_nxt;
      cols_r      <= cols_nxt;
      rows_r      <= rows_nxt;
      walk_x_r    <= walk_x_nxt;
      walk_y_r    <= walk_y_nxt;
      heading_r   <= heading_nxt;
      steps_r     <= steps_nxt;
      leg_r       <= leg_nxt;
      id_r        <= id_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // products and result payload
  always_ff @(posedge clk) begin
    ox_r      <= ox_nxt;
    oy_r      <= oy_nxt;
    tile_id_r <= tile_id_nxt;
    org_x_r   <= org_x_nxt;
    org_y_r   <= org_y_nxt;
    size_x_r  <= size_x_nxt;
    size_y_r  <= size_y_nxt;
    done_r    <= done_nxt;
  end

  assign stat.no_req   = !in_accept;
  assign stat.restart  = restart_r;
  assign stat.div_busy = div_busy;
  assign stat.finished = fin_r;
  assign stat.outside  = !cur_inside;
  assign stat.out_full = out_valid_r && !out_ready;

  assign out_valid    = out_valid_r;
  assign out_tile_id  = tile_id_r;
  assign out_origin_x = org_x_r;
  assign out_origin_y = org_y_r;
  assign out_size_x   = size_x_r;
  assign out_size_y   = size_y_r;
  assign out_done_res = done_r;

endmodule

// ===== design/sts_sequencer.sv =====
// ----------------------------------------------------------------------------
// sts_sequencer
// Step counter over the control store with conditional jumps.
// ----------------------------------------------------------------------------
module sts_sequencer
  import sts_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  stat_t stat,
  output op_t   op
);

  pc_t    pc_r, pc_nxt;
  uword_t uw;
  logic   take;

  assign uw = ucode_rom(pc_r);

  // evaluate the jump condition of the current step
  always_comb begin
    case (uw.cond)
      C_NEVER:      take = 1'b0;
      C_ALWAYS:     take = 1'b1;
      C_NO_REQ:     take = stat.no_req;
      C_NO_RESTART: take = !stat.restart;
      C_DIV_BUSY:   take = stat.div_busy;
      C_FINISHED:   take = stat.finished;
      C_OUTSIDE:    take = stat.outside;
      C_OUT_FULL:   take = stat.out_full;
      default:      take = 1'b0;
    endcase
    pc_nxt = take ? uw.target : pc_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign op = uw.op;

endmodule

// ===== bench/tile_order_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_order_checker
// Watches the request, result and register channels of the spiral tile order
// generator. Keeps its own copy of the registers and of the spiral walk, works
// out the tile that each accepted request must return, and compares every
// accepted result, field by field, against the oldest tile still owed.
// ----------------------------------------------------------------------------
module tile_order_checker
  import sts_pkg::*;
#(
  parameter int MAX_IMAGE_EDGE = 8192,
  parameter int MAX_TILE_EDGE  = 256
) (
  input  logic clk,
  input  logic rst_n,
  sts_in_if    in_ch,
  sts_out_if   out_ch,
  sts_cfg_if   cfg_ch,
  output int   mismatches,
  output int   tiles_due
);

  typedef enum logic [1:0] {HEAD_UP, HEAD_LEFT, HEAD_DOWN, HEAD_RIGHT} heading_t;

  typedef struct packed {
    logic [ID_W-1:0]   tile_id;
    logic [ORG_W-1:0]  origin_x;
    logic [ORG_W-1:0]  origin_y;
    logic [TILE_W-1:0] size_x;
    logic [TILE_W-1:0] size_y;
    logic              done_res;
  } tile_rec_t;

  // register copy
  logic [DIM_W-1:0]  reg_width;
  logic [DIM_W-1:0]  reg_height;
  logic [TILE_W-1:0] reg_tile;

  // walk copy
  int              col_pos;
  int              row_pos;
  int              grid_cols;
  int              grid_rows;
  heading_t        dir;
  int unsigned     leg_steps;
  int unsigned     leg_len;
  logic [ID_W-1:0] id_next;
  bit              walk_over;

  tile_rec_t expected_tiles[$];
  int        fail_tally;
  int        results_seen;
  bit        field_bad;

  function automatic int unsigned clamp_len(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic bit in_cols(int c);
    return c >= 0 && c < grid_cols;
  endfunction

  function automatic bit in_rows(int r);
    return r >= 0 && r < grid_rows;
  endfunction

  // rebuild the grid from the current registers and return to the centre
  function automatic void restart_walk();
    int unsigned te;
    te = clamp_len(reg_tile, MAX_TILE_EDGE);
    grid_cols = (clamp_len(reg_width, MAX_IMAGE_EDGE) + te - 1) / te;
    grid_rows = (clamp_len(reg_height, MAX_IMAGE_EDGE) + te - 1) / te;
    col_pos   = grid_cols / 2;
    row_pos   = grid_rows / 2;
    dir       = HEAD_UP;
    leg_steps = 0;
    leg_len   = 1;
    id_next   = '0;
    walk_over = 1'b0;
  endfunction

  // one spiral step; the leg grows on every turn onto a vertical heading
  function automatic void step_walk();
    if (leg_steps >= leg_len) begin
      dir = heading_t'(dir + 2'd1);
      leg_steps = 0;
      if (dir == HEAD_UP || dir == HEAD_DOWN) leg_len++;
    end
    case (dir)
      HEAD_UP:   row_pos--;
      HEAD_LEFT: col_pos--;
      HEAD_DOWN: row_pos++;
      default:   col_pos++;
    endcase
    leg_steps++;
    if (!in_cols(col_pos) && !in_rows(row_pos)) walk_over = 1'b1;
  endfunction

  // tile size clipped at the image edge, zero once the origin is past it
  function automatic int unsigned clip_span(int unsigned te, int unsigned limit,
                                            int unsigned org);
    if (org >= limit) return 0;
    return (te < limit - org) ? te : limit - org;
  endfunction

  // next on-image tile, stepping over off-image positions
  function automatic tile_rec_t predict_tile(input logic restart);
    tile_rec_t   rec;
    int unsigned te;
    int unsigned ox;
    int unsigned oy;
    int unsigned sx;
    int unsigned sy;
    rec = '0;
    if (restart) restart_walk();
    while (!walk_over) begin
      if (in_cols(col_pos) && in_rows(row_pos)) begin
        te = clamp_len(reg_tile, MAX_TILE_EDGE);
        ox = $unsigned(col_pos) * te;
        oy = $unsigned(row_pos) * te;
        sx = clip_span(te, clamp_len(reg_width, MAX_IMAGE_EDGE), ox);
        sy = clip_span(te, clamp_len(reg_height, MAX_IMAGE_EDGE), oy);
        rec.tile_id  = id_next;
        rec.origin_x = ox[ORG_W-1:0];
        rec.origin_y = oy[ORG_W-1:0];
        rec.size_x   = sx[TILE_W-1:0];
        rec.size_y   = sy[TILE_W-1:0];
        id_next++;
        step_walk();
        return rec;
      end
      step_walk();
    end
    rec.done_res = 1'b1;
    return rec;
  endfunction

  task automatic flag_field(input string field, input int unsigned want,
                            input int unsigned got);
    if (want != got) begin
      field_bad = 1'b1;
      if (fail_tally < 10)
        $display("[%0t] tile result %0d: %s expected %0d, got %0d",
                 $time, results_seen, field, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    tile_rec_t want;
    if (!rst_n) begin
      reg_width  = DIM_W'(IMAGE_WIDTH_RESET);
      reg_height = DIM_W'(IMAGE_HEIGHT_RESET);
      reg_tile   = TILE_W'(TILE_EDGE_RESET);
      restart_walk();
      expected_tiles.delete();
      fail_tally   = 0;
      results_seen = 0;
    end else begin
      // compare a returned tile against the oldest one owed
      if (out_ch.valid && out_ch.ready) begin
        if (expected_tiles.size() == 0) begin
          if (fail_tally < 10)
            $display("[%0t] tile result %0d arrived with no request outstanding",
                     $time, results_seen);
          fail_tally++;
        end else begin
          want = expected_tiles.pop_front();
          field_bad = 1'b0;
          flag_field("tile_id",  want.tile_id,  out_ch.tile_id);
          flag_field("origin_x", want.origin_x, out_ch.origin_x);
          flag_field("origin_y", want.origin_y, out_ch.origin_y);
          flag_field("size_x",   want.size_x,   out_ch.size_x);
          flag_field("size_y",   want.size_y,   out_ch.size_y);
          flag_field("done_res", want.done_res, out_ch.done_res);
          if (field_bad) fail_tally++;
        end
        results_seen++;
      end
      // register writes
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_IMAGE_WIDTH:  reg_width  = cfg_ch.data;
          CFG_IMAGE_HEIGHT: reg_height = cfg_ch.data;
          CFG_TILE_EDGE:    reg_tile   = cfg_ch.data[TILE_W-1:0];
          default: ;
        endcase
      end
      // each request owes exactly one result
      if (in_ch.valid && in_ch.ready) begin
        want = predict_tile(in_ch.restart);
        expected_tiles = {expected_tiles, want};
      end
    end
    tiles_due  <= expected_tiles.size();
    mismatches <= fail_tally;
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the spiral tile order generator. A short directed
// run covers the reset grid, extreme and out-of-range registers, clipped edge
// tiles, the end of the walk and register changes without a restart; random
// phases follow with bounded grids, random restarts, bursty requests and a
// stalling result receiver. Checking lives in tile_order_checker.
// ----------------------------------------------------------------------------
module tb_top
  import sts_pkg::*;
;

  localparam int MAX_IMAGE_EDGE = 8192;
  localparam int MAX_TILE_EDGE  = 256;
  localparam int REQUEST_TARGET = 1100;
  localparam int GRID_CAP       = 40;
  localparam int QUIET_LIMIT    = 5000;

  logic clk;
  logic rst_n;

  sts_in_if  in_ch ();
  sts_out_if out_ch ();
  sts_cfg_if cfg_ch ();

  int mismatches;
  int tiles_due;
  int quiet_cycles;

  // stimulus bookkeeping
  int                    requests_sent;
  int                    burst_left;
  int unsigned           last_cells;
  logic [CFG_DATA_W-1:0] sh_width;
  logic [CFG_DATA_W-1:0] sh_height;
  logic [CFG_DATA_W-1:0] sh_tile;

  spiral_tile_order_generator #(
    .MAX_IMAGE_EDGE (MAX_IMAGE_EDGE),
    .MAX_TILE_EDGE  (MAX_TILE_EDGE)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  tile_order_checker #(
    .MAX_IMAGE_EDGE (MAX_IMAGE_EDGE),
    .MAX_TILE_EDGE  (MAX_TILE_EDGE)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .mismatches (mismatches),
    .tiles_due  (tiles_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // grid span along one axis for raw register values
  function automatic int unsigned grid_span(int unsigned len, int unsigned tile_raw);
    int unsigned l;
    int unsigned te;
    l  = (len < 1) ? 1 : ((len > MAX_IMAGE_EDGE) ? MAX_IMAGE_EDGE : len);
    te = tile_raw % 512;
    te = (te < 1) ? 1 : ((te > MAX_TILE_EDGE) ? MAX_TILE_EDGE : te);
    return (l + te - 1) / te;
  endfunction

  // image length whose grid span stays within the cap for this tile
  function automatic int unsigned bounded_len(int unsigned tile_raw);
    int unsigned te;
    int unsigned len;
    te = tile_raw % 512;
    te = (te < 1) ? 1 : ((te > MAX_TILE_EDGE) ? MAX_TILE_EDGE : te);
    do begin
      case ($urandom_range(0, 5))
        0:       len = 0;
        1:       len = MAX_IMAGE_EDGE;
        2:       len = $urandom_range(MAX_IMAGE_EDGE + 1, 16383);
        3:       len = te * $urandom_range(1, GRID_CAP);
        default: len = $urandom_range(1, te * 12);
      endcase
    end while (grid_span(len, tile_raw) > GRID_CAP);
    return len;
  endfunction

  // hold a register write until it is taken; the caller drops valid
  task automatic write_reg(input cfg_idx_t idx, input int unsigned data);
    logic [CFG_DATA_W-1:0] val;
    val = CFG_DATA_W'(data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      CFG_IMAGE_WIDTH:  sh_width  = val;
      CFG_IMAGE_HEIGHT: sh_height = val;
      CFG_TILE_EDGE:    sh_tile   = val;
      default: ;
    endcase
  endtask

  // one request, with a random gap between bursts
  task automatic send_request(input logic restart);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_ch.valid   <= 1'b1;
    in_ch.restart <= restart;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
    requests_sent++;
  endtask

  // stop requesting until every owed tile has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (tiles_due != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // result receiver: stall on a bit pattern that changes now and then
  initial begin : receiver
    logic [15:0] stall_mask;
    int          hold_left;
    out_ch.ready <= 1'b0;
    hold_left = 0;
    stall_mask = '1;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_left == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_mask = '1;
          1:       stall_mask = 16'($urandom());
          2:       stall_mask = 16'($urandom() & $urandom());
          default: stall_mask = 16'($urandom() | $urandom());
        endcase
        stall_mask[0] = 1'b1;
        hold_left = $urandom_range(32, 160);
      end
      out_ch.ready <= stall_mask[hold_left[3:0]];
      hold_left--;
      @(posedge clk);
    end
  end

  // watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL spiral_tile_order_generator");
        $finish;
      end
    end
  end

  initial begin : stimulus
    bit with_restart;
    int n;
    in_ch.valid   <= 1'b0;
    in_ch.restart <= 1'b0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= CFG_IMAGE_WIDTH;
    cfg_ch.data   <= '0;
    rst_n         <= 1'b0;
    requests_sent = 0;
    burst_left    = 0;
    sh_width      = CFG_DATA_W'(IMAGE_WIDTH_RESET);
    sh_height     = CFG_DATA_W'(IMAGE_HEIGHT_RESET);
    sh_tile       = CFG_DATA_W'(TILE_EDGE_RESET);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset grid, no restart
    send_request(1'b0);
    send_request(1'b0);

    // largest image and tile
    drain();
    write_reg(CFG_IMAGE_WIDTH, MAX_IMAGE_EDGE);
    write_reg(CFG_IMAGE_HEIGHT, MAX_IMAGE_EDGE);
    write_reg(CFG_TILE_EDGE, MAX_TILE_EDGE);
    cfg_ch.valid <= 1'b0;
    send_request(1'b1);
    send_request(1'b0);

    // single-pixel tiles on a one-row image: off-image steps between tiles
    drain();
    write_reg(CFG_TILE_EDGE, 1);
    write_reg(CFG_IMAGE_HEIGHT, 1);
    cfg_ch.valid <= 1'b0;
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);

    // out-of-range registers: clamp width up, height and tile down
    drain();
    write_reg(CFG_IMAGE_WIDTH, 0);
    write_reg(CFG_IMAGE_HEIGHT, 14'h3FFF);
    write_reg(CFG_TILE_EDGE, 14'h3FFF);
    cfg_ch.valid <= 1'b0;
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);

    // one-tile grid: walk ends after the first tile
    drain();
    write_reg(CFG_TILE_EDGE, 0);
    write_reg(CFG_IMAGE_WIDTH, 1);
    write_reg(CFG_IMAGE_HEIGHT, 1);
    cfg_ch.valid <= 1'b0;
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);

    // two by two grid: done results until the restart, whose tile is clipped right and bottom
    drain();
    write_reg(CFG_IMAGE_WIDTH, 100);
    write_reg(CFG_IMAGE_HEIGHT, 70);
    write_reg(CFG_TILE_EDGE, 64);
    cfg_ch.valid <= 1'b0;
    repeat (5) send_request(1'b0);
    send_request(1'b1);

    // change the tile edge without a restart: origins past the right edge, zero widths
    drain();
    write_reg(CFG_IMAGE_WIDTH, 40);
    write_reg(CFG_IMAGE_HEIGHT, 3);
    write_reg(CFG_TILE_EDGE, 1);
    cfg_ch.valid <= 1'b0;
    send_request(1'b1);
    send_request(1'b0);
    drain();
    write_reg(CFG_TILE_EDGE, MAX_TILE_EDGE);
    cfg_ch.valid <= 1'b0;
    send_request(1'b0);
    send_request(1'b0);
    last_cells = 120;

    // random phases
    while (requests_sent < REQUEST_TARGET) begin
      with_restart = ($urandom_range(0, 5) != 0);
      if (with_restart || $urandom_range(0, 3) != 0) begin
        drain();
        if (with_restart) begin
          // keep the rebuilt grid small enough to walk out of
          if ($urandom_range(0, 1) != 0) begin
            case ($urandom_range(0, 5))
              0:       write_reg(CFG_TILE_EDGE, $urandom_range(1, 8));
              1:       write_reg(CFG_TILE_EDGE, $urandom_range(9, MAX_TILE_EDGE));
              2:       write_reg(CFG_TILE_EDGE, ($urandom_range(0, 1) != 0) ?
                                                 MAX_TILE_EDGE : 1);
              3:       write_reg(CFG_TILE_EDGE, 0);
              4:       write_reg(CFG_TILE_EDGE, $urandom_range(MAX_TILE_EDGE + 1, 16383));
              default: write_reg(CFG_TILE_EDGE, $urandom_range(16, 64));
            endcase
          end
          if ($urandom_range(0, 1) != 0 || grid_span(sh_width, sh_tile) > GRID_CAP)
            write_reg(CFG_IMAGE_WIDTH, bounded_len(sh_tile));
          if ($urandom_range(0, 1) != 0 || grid_span(sh_height, sh_tile) > GRID_CAP)
            write_reg(CFG_IMAGE_HEIGHT, bounded_len(sh_tile));
          last_cells = grid_span(sh_width, sh_tile) * grid_span(sh_height, sh_tile);
        end else begin
          // any values; the grid stays as last built
          repeat ($urandom_range(1, 3))
            write_reg(cfg_idx_t'($urandom_range(0, 2)), $urandom_range(0, 16383));
        end
        cfg_ch.valid <= 1'b0;
      end
      if ($urandom_range(0, 3) == 0)
        n = (last_cells + 3 > 80) ? 80 : last_cells + 3;
      else
        n = $urandom_range(1, 30);
      for (int k = 0; k < n; k++)
        send_request(with_restart && (k == 0 || $urandom_range(0, 24) == 0));
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS spiral_tile_order_generator");
    end else begin
      $display("FAIL spiral_tile_order_generator");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/sts_pkg.sv
design/sts_in_if.sv
design/sts_out_if.sv
design/sts_cfg_if.sv
design/sts_divider.sv
design/sts_datapath.sv
design/sts_sequencer.sv
design/spiral_tile_order_generator.sv
bench/tile_order_checker.sv
bench/tb_top.sv
